// ===== rtl/core/stack_machine_execute_top_defines.svh =====
// Assertion macros for the stack machine RTL.
`ifndef STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
// Property that must hold whenever the enabling condition holds.
`define SME_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Property checked in the cycle after the enabling condition.
`define SME_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sme_pkg.sv =====
// Shared types and constants for the stack machine executor.
`timescale 1ns / 1ps
package sme_pkg;
  localparam int PC_W = 11;
  localparam int DATA_W = 32;
  localparam int MODE_W = 5;

  localparam logic [4:0] OP_BEGIN = 5'd0;
  localparam logic [4:0] OP_END   = 5'd1;
  localparam logic [4:0] OP_PUSH  = 5'd2;
  localparam logic [4:0] OP_POP   = 5'd3;
  localparam logic [4:0] OP_PUSHR = 5'd4;
  localparam logic [4:0] OP_POPR  = 5'd5;
  localparam logic [4:0] OP_ADD   = 5'd6;
  localparam logic [4:0] OP_SUB   = 5'd7;
  localparam logic [4:0] OP_MUL   = 5'd8;
  localparam logic [4:0] OP_DIV   = 5'd9;
  localparam logic [4:0] OP_OUT   = 5'd10;
  localparam logic [4:0] OP_IN    = 5'd11;
  localparam logic [4:0] OP_JMP   = 5'd12;
  localparam logic [4:0] OP_JEQ   = 5'd13;
  localparam logic [4:0] OP_JNE   = 5'd14;
  localparam logic [4:0] OP_JA    = 5'd15;
  localparam logic [4:0] OP_JAE   = 5'd16;
  localparam logic [4:0] OP_JB    = 5'd17;
  localparam logic [4:0] OP_JBE   = 5'd18;
  localparam logic [4:0] OP_CALL  = 5'd19;
  localparam logic [4:0] OP_RET   = 5'd20;

  localparam logic [1:0] F_NONE  = 2'd0;
  localparam logic [1:0] F_UNDER = 2'd1;
  localparam logic [1:0] F_OVER  = 2'd2;
  localparam logic [1:0] F_DIVZ  = 2'd3;

  // Classified request passed from front to back.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;   // immediate or in_value, chosen by front
    logic [2:0]        reg_index;
    logic [9:0]        target;
    logic [1:0]        need;    // stack entries read
    logic              pushes;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_MUL, S_WR, S_DONE
  } bstate_t;
endpackage

// ===== rtl/core/stack_machine_execute_top.sv =====
// Stack machine executor: one instruction request in, one result out.
// Each instruction steps through read, execute, write and done states; MUL adds a
// multiply state and DIV waits on the one-bit-per-cycle divider.
// The back end runs one instruction at a time, taking a new one only when idle;
// a two-entry queue lets the front keep accepting while it has room.
// Reset (synchronous, rst_n low): stack empty, registers, PC, run flag and
// program length zero.
`timescale 1ns / 1ps
module stack_machine_execute_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] immediate, [34:32] reg_index, [44:35] target, [76:45] in_value,
  // [79:77] zero
  input  logic [79:0] in_tdata,
  // [4:0] mode
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] pc_value, [11] running, [43:12] out_value, [45:44] fault,
  // [47:46] zero
  output logic [47:0] out_tdata,
  // [0] ov_valid, the out_value valid flag
  output logic        out_tuser
);
  logic [10:0] plen_r;
  logic q_valid, q_pop;
  sme_pkg::req_t q_req;
  logic [10:0] pc_value;
  logic running, ovv;
  logic [31:0] ovval;
  logic [1:0] fault;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) plen_r <= 11'd0;
    else if (cfg_valid) plen_r <= cfg_data;
  end

  sme_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tuser), .immediate(in_tdata[31:0]),
    .reg_index(in_tdata[34:32]), .target(in_tdata[44:35]),
    .in_value(in_tdata[76:45]), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  sme_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .program_length(plen_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .pc_value(pc_value), .running(running), .ov_valid(ovv), .ov_value(ovval),
    .fault(fault)
  );

  assign out_tdata = {2'b00, fault, ovval, running, pc_value};
  assign out_tuser = ovv;
endmodule

// ===== rtl/core/sme_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/sme_front.sv =====
// Front end: accepts instructions, classifies them, two-entry queue.
`timescale 1ns / 1ps
module sme_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [4:0]    mode,
  input  logic [31:0]   immediate,
  input  logic [2:0]    reg_index,
  input  logic [9:0]    target,
  input  logic [31:0]   in_value,
  output logic          q_valid,
  input  logic          q_pop,
  output sme_pkg::req_t q_req
);
  sme_pkg::req_t cls;
  sme_pkg::req_t slot_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  always_comb begin
    cls.mode = mode;
    cls.value = (mode == sme_pkg::OP_IN) ? in_value : immediate;
    cls.reg_index = reg_index;
    cls.target = target;
    cls.need = 2'd0;
    cls.pushes = 1'b0;
    case (mode)
      sme_pkg::OP_POP, sme_pkg::OP_POPR, sme_pkg::OP_OUT, sme_pkg::OP_RET: cls.need = 2'd1;
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
      sme_pkg::OP_JEQ, sme_pkg::OP_JNE, sme_pkg::OP_JA, sme_pkg::OP_JAE,
      sme_pkg::OP_JB, sme_pkg::OP_JBE: cls.need = 2'd2;
      sme_pkg::OP_PUSH, sme_pkg::OP_PUSHR, sme_pkg::OP_IN, sme_pkg::OP_CALL:
        cls.pushes = 1'b1;
      default: ;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = slot_r[rd_r];
  assign rd_nxt = rd_r ^ q_pop;
  assign wr_nxt = wr_r ^ push;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wr_r] <= cls;
  end
endmodule

// ===== rtl/core/sme_div.sv =====
// Iterative 32-bit signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r, q_r, d_r;
  logic [5:0] cnt_r;
  logic busy_r, neg_r;
  logic [32:0] trial;
  logic [31:0] rshift;

  assign rshift = {rem_r[30:0], q_r[31]};
  assign trial = {1'b0, rshift} - {1'b0, d_r};
  assign done = busy_r && (cnt_r == 6'd0);
  assign quo = neg_r ? (32'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd32;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
    end
    if (start) begin
      rem_r <= 32'd0;
      q_r <= num[31] ? (32'd0 - num) : num;
      d_r <= den[31] ? (32'd0 - den) : den;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rshift;
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/sme_back.sv =====
// Back end: executes queued instructions against stack and registers.
`timescale 1ns / 1ps
`include "stack_machine_execute_top_defines.svh"
module sme_back #(
  parameter int STACK_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  sme_pkg::req_t q_req,
  input  logic [10:0]   program_length,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [10:0]   pc_value,
  output logic          running,
  output logic          ov_valid,
  output logic [31:0]   ov_value,
  output logic [1:0]    fault
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SPW = AW + 1;

  sme_pkg::bstate_t st_r, st_nxt;
  sme_pkg::req_t req_r;
  logic [SPW-1:0] sp_r;
  logic [31:0] gr_r [6];
  logic [10:0] pc_r;
  logic run_r;
  logic [31:0] top_r, next_r, prod_r;
  logic [AW-1:0] raddr;
  logic [31:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata_r;
  logic [AW-1:0] waddr_r;
  logic wdata_valid_r;
  logic div_start, div_done;
  logic [31:0] quo;
  logic [10:0] pc_o_r;
  logic run_o_r, ovv_r;
  logic [31:0] ov_r;
  logic [1:0] f_r;
  logic ld_top, ld_next, exec, take;
  logic [1:0] flt;
  logic [10:0] tgt_m1, pc_adv;
  logic cmp, active;
  logic [31:0] regval;
  logic signed [31:0] sa, sb;

  assign take = q_valid && st_r == sme_pkg::S_IDLE;
  assign q_pop = take;
  assign active = req_r.mode == sme_pkg::OP_BEGIN || run_r;

  sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_r), .raddr(raddr), .rdata(rdata)
  );
  sme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(top_r), .den(next_r),
    .done(div_done), .quo(quo)
  );

  // Read address: top first, then next.
  always_comb begin
    if (st_r == sme_pkg::S_IDLE) raddr = AW'(sp_r - SPW'(1));
    else raddr = AW'(sp_r - SPW'(2));
  end

  always_comb begin
    flt = sme_pkg::F_NONE;
    if (req_r.mode != sme_pkg::OP_BEGIN && run_r) begin
      if (sp_r < SPW'(req_r.need)) flt = sme_pkg::F_UNDER;
      else if (req_r.pushes && sp_r >= SPW'(STACK_DEPTH)) flt = sme_pkg::F_OVER;
      else if (req_r.mode == sme_pkg::OP_DIV && next_r == 32'd0) flt = sme_pkg::F_DIVZ;
    end
  end

  always_comb begin
    sa = top_r;
    sb = next_r;
    case (req_r.mode)
      sme_pkg::OP_JEQ: cmp = sa == sb;
      sme_pkg::OP_JNE: cmp = sa != sb;
      sme_pkg::OP_JA:  cmp = sa > sb;
      sme_pkg::OP_JAE: cmp = sa >= sb;
      sme_pkg::OP_JB:  cmp = sa < sb;
      default:         cmp = sa <= sb;
    endcase
    if (req_r.reg_index == 3'd6) regval = {21'd0, pc_r};
    else if (req_r.reg_index < 3'd6) regval = gr_r[req_r.reg_index];
    else regval = 32'd0;
  end

  assign tgt_m1 = {1'b0, req_r.target} - 11'd1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sme_pkg::S_IDLE: if (q_valid) st_nxt = sme_pkg::S_RD1;
      sme_pkg::S_RD1:  st_nxt = sme_pkg::S_RD2;
      sme_pkg::S_RD2:  st_nxt = sme_pkg::S_EXEC;
      sme_pkg::S_EXEC: begin
        if (active && flt == sme_pkg::F_NONE && req_r.mode == sme_pkg::OP_DIV)
          st_nxt = sme_pkg::S_DIV;
        else if (active && flt == sme_pkg::F_NONE && req_r.mode == sme_pkg::OP_MUL)
          st_nxt = sme_pkg::S_MUL;
        else st_nxt = sme_pkg::S_WR;
      end
      sme_pkg::S_DIV:  if (div_done) st_nxt = sme_pkg::S_WR;
      sme_pkg::S_MUL:  st_nxt = sme_pkg::S_WR;
      sme_pkg::S_WR:   st_nxt = sme_pkg::S_DONE;
      sme_pkg::S_DONE: if (out_ready) st_nxt = sme_pkg::S_IDLE;
      default:         st_nxt = sme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ld_top = st_r == sme_pkg::S_RD1;
    ld_next = st_r == sme_pkg::S_RD2;
    exec = st_r == sme_pkg::S_EXEC;
    div_start = exec && st_nxt == sme_pkg::S_DIV;
    we = st_r == sme_pkg::S_WR && wdata_valid_r;
    waddr = waddr_r;
    out_valid = st_r == sme_pkg::S_DONE;
  end

  assign pc_adv = pc_r + 11'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sme_pkg::S_IDLE;
      sp_r <= '0;
      pc_r <= '0;
      run_r <= 1'b0;
      wdata_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) gr_r[i] <= 32'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == sme_pkg::S_WR) wdata_valid_r <= 1'b0;
      if (st_r == sme_pkg::S_DIV && div_done) wdata_valid_r <= 1'b1;
      if (st_r == sme_pkg::S_MUL) wdata_valid_r <= 1'b1;
      if (exec) begin
        if (req_r.mode == sme_pkg::OP_BEGIN) begin
          run_r <= 1'b1;
          pc_r <= pc_adv;
        end else if (!run_r || flt != sme_pkg::F_NONE) begin
          pc_r <= pc_adv;
        end else begin
          pc_r <= pc_adv;
          case (req_r.mode)
            sme_pkg::OP_END: begin
              run_r <= 1'b0;
              pc_r <= program_length;
            end
            sme_pkg::OP_PUSH, sme_pkg::OP_IN: begin
              wdata_valid_r <= 1'b1;
              sp_r <= sp_r + SPW'(1);
            end
            sme_pkg::OP_PUSHR: begin
              wdata_valid_r <= 1'b1;
              sp_r <= sp_r + SPW'(1);
            end
            sme_pkg::OP_POP, sme_pkg::OP_OUT: sp_r <= sp_r - SPW'(1);
            sme_pkg::OP_POPR: begin
              sp_r <= sp_r - SPW'(1);
              if (req_r.reg_index == 3'd6) pc_r <= top_r[10:0] + 11'd1;
              else if (req_r.reg_index < 3'd6) gr_r[req_r.reg_index] <= top_r;
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
              wdata_valid_r <= 1'b1;
              sp_r <= sp_r - SPW'(1);
            end
            sme_pkg::OP_MUL, sme_pkg::OP_DIV: sp_r <= sp_r - SPW'(1);
            sme_pkg::OP_JMP: pc_r <= tgt_m1 + 11'd1;
            sme_pkg::OP_JEQ, sme_pkg::OP_JNE, sme_pkg::OP_JA, sme_pkg::OP_JAE,
            sme_pkg::OP_JB, sme_pkg::OP_JBE: if (cmp) pc_r <= tgt_m1 + 11'd1;
            sme_pkg::OP_CALL: begin
              wdata_valid_r <= 1'b1;
              sp_r <= sp_r + SPW'(1);
              pc_r <= tgt_m1 + 11'd1;
            end
            sme_pkg::OP_RET: begin
              sp_r <= sp_r - SPW'(1);
              pc_r <= top_r[10:0] + 11'd1;
            end
            default: ;
          endcase
        end
      end
    end
    if (take) req_r <= q_req;
    if (ld_top) top_r <= rdata;
    if (ld_next) next_r <= rdata;
    if (st_r == sme_pkg::S_EXEC) prod_r <= top_r * next_r;
    if (exec) begin
      ovv_r <= 1'b0;
      ov_r <= 32'd0;
      f_r <= flt;
      case (req_r.mode)
        sme_pkg::OP_PUSH, sme_pkg::OP_IN: begin
          wdata_r <= req_r.value;
          waddr_r <= AW'(sp_r);
        end
        sme_pkg::OP_PUSHR: begin
          wdata_r <= regval;
          waddr_r <= AW'(sp_r);
        end
        sme_pkg::OP_CALL: begin
          wdata_r <= {21'd0, pc_r};
          waddr_r <= AW'(sp_r);
        end
        sme_pkg::OP_ADD: begin
          wdata_r <= top_r + next_r;
          waddr_r <= AW'(sp_r - SPW'(2));
        end
        sme_pkg::OP_SUB: begin
          wdata_r <= top_r - next_r;
          waddr_r <= AW'(sp_r - SPW'(2));
        end
        default: waddr_r <= AW'(sp_r - SPW'(2));
      endcase
      if (run_r && flt == sme_pkg::F_NONE && req_r.mode == sme_pkg::OP_OUT) begin
        ovv_r <= 1'b1;
        ov_r <= top_r;
      end
    end
    if (st_r == sme_pkg::S_DIV && div_done) wdata_r <= quo;
    if (st_r == sme_pkg::S_MUL) wdata_r <= prod_r;
    if (st_r == sme_pkg::S_WR) begin
      pc_o_r <= pc_r;
      run_o_r <= run_r;
    end
  end

  assign pc_value = pc_o_r;
  assign running = run_o_r;
  assign ov_valid = ovv_r;
  assign ov_value = ov_r;
  assign fault = f_r;

  `SME_ASSERT_IMP(a_sp_range, clk, rst_n, 1'b1, sp_r <= SPW'(STACK_DEPTH))
  `SME_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == sme_pkg::S_IDLE && q_valid)
  `SME_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pc_value))
  `SME_ASSERT_IMP(a_ovv_nofault, clk, rst_n, out_valid && ov_valid, fault == sme_pkg::F_NONE)
endmodule
